/* hdl/tilp_pkg.sv */
package tilp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;

	localparam logic [1:0] TOKENS_MAX = 2'd2;

	localparam logic LINE_PARSED  = 1'b0;
	localparam logic LINE_DROPPED = 1'b1;

	// what the back end has to do with one beat
	typedef enum logic [1:0] {
		OP_CHAR = 2'd0,
		OP_END  = 2'd1,
		OP_DROP = 2'd2
	} op_kind_t;

	typedef enum logic [2:0] {
		CLS_ZERO   = 3'd0,
		CLS_SPACE  = 3'd1,
		CLS_INNER  = 3'd2,
		CLS_PLUS   = 3'd3,
		CLS_MINUS  = 3'd4,
		CLS_DIGIT  = 3'd5,
		CLS_OTHER  = 3'd6
	} char_cls_t;

	typedef enum logic [3:0] {
		PH_BETWEEN = 4'b0001,
		PH_SKIP    = 4'b0010,
		PH_DIGITS  = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	typedef struct packed {
		op_kind_t  kind;
		char_cls_t cls;
		logic [3:0] digit;
	} op_t;

endpackage

/* hdl/tilp_front.sv */
module tilp_front
	import tilp_pkg::*;
#(
	parameter int unsigned LINE_BUFFER_SIZE = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       in_ready,
	output logic       push,
	output op_t        push_op
);

	localparam int unsigned CNT_W = $clog2(LINE_BUFFER_SIZE);
	localparam logic [CNT_W-1:0] DROP_AT = CNT_W'(LINE_BUFFER_SIZE - 2);

	logic [CNT_W-1:0] char_count_q;
	logic             is_term;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign is_term  = (rx_byte == CH_LF) || (rx_byte == CH_CR);

	always_comb begin
		push_op.digit = rx_byte[3:0];
		case (rx_byte) inside
			CH_NUL:             push_op.cls = CLS_ZERO;
			CH_SPACE:           push_op.cls = CLS_SPACE;
			[CH_TAB:CH_CR]:     push_op.cls = CLS_INNER;
			CH_PLUS:            push_op.cls = CLS_PLUS;
			CH_MINUS:           push_op.cls = CLS_MINUS;
			[CH_DIG0:CH_DIG9]:  push_op.cls = CLS_DIGIT;
			default:            push_op.cls = CLS_OTHER;
		endcase
		// a terminator on an empty line is stored like any other character
		if (is_term && char_count_q != '0) begin
			push_op.kind = OP_END;
		end else if (char_count_q == DROP_AT) begin
			push_op.kind = OP_DROP;
		end else begin
			push_op.kind = OP_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
		end else if (push) begin
			if (push_op.kind == OP_CHAR) begin
				char_count_q <= char_count_q + 1'b1;
			end else begin
				char_count_q <= '0;
			end
		end
	end

endmodule

/* hdl/tilp_queue.sv */
module tilp_queue
	import tilp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output op_t  head_op
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_op   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/tilp_back.sv */
module tilp_back
	import tilp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  op_t                q_op,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] flow_x,
	output logic signed [15:0] flow_y,
	output logic [1:0]         tokens_used,
	output logic               line_status
);

	// per-line parse state
	phase_t      phase_q,   phase_n;
	logic [1:0]  idx_q,     idx_n;
	logic        neg_q,     neg_n;
	logic [15:0] acc_q,     acc_n;
	logic [15:0] pf_q,      pf_n;
	logic [15:0] ps_q,      ps_n;
	logic        zero_q,    zero_n;
	logic [15:0] held_x_q,  held_x_n;
	logic [15:0] held_y_q,  held_y_n;

	// outcome of closing the current token
	logic [1:0]  fin_idx;
	logic [15:0] fin_pf;
	logic [15:0] fin_ps;
	logic [15:0] fin_val;

	phase_t      ph;
	logic [15:0] acc_x10;
	logic        out_valid_q;
	logic [15:0] flow_x_q;
	logic [15:0] flow_y_q;
	logic [1:0]  tokens_q;
	logic        status_q;
	logic        emit;

	assign pop      = q_not_empty && (!out_valid_q || out_ready);
	assign emit     = pop && (q_op.kind != OP_CHAR);
	assign acc_x10  = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0};
	assign fin_val  = neg_q ? (16'd0 - acc_q) : acc_q;

	always_comb begin
		fin_idx = idx_q;
		fin_pf  = pf_q;
		fin_ps  = ps_q;
		if (phase_q != PH_BETWEEN && idx_q < TOKENS_MAX) begin
			if (idx_q == 2'd0) begin
				fin_pf = fin_val;
			end else begin
				fin_ps = fin_val;
			end
			fin_idx = idx_q + 1'b1;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		neg_n    = neg_q;
		acc_n    = acc_q;
		pf_n     = pf_q;
		ps_n     = ps_q;
		zero_n   = zero_q;
		held_x_n = held_x_q;
		held_y_n = held_y_q;
		ph       = phase_q;
		case (q_op.kind)
			OP_CHAR: begin
				if (!zero_q) begin
					if (q_op.cls == CLS_ZERO) begin
						zero_n = 1'b1;
					end else if (q_op.cls == CLS_SPACE) begin
						idx_n   = fin_idx;
						pf_n    = fin_pf;
						ps_n    = fin_ps;
						phase_n = PH_BETWEEN;
					end else begin
						if (phase_q == PH_BETWEEN) begin
							if (idx_q >= TOKENS_MAX) begin
								ph = PH_DONE;
							end else begin
								ph    = PH_SKIP;
								neg_n = 1'b0;
								acc_n = '0;
							end
						end
						phase_n = ph;
						case (ph)
							PH_SKIP: begin
								case (q_op.cls)
									CLS_INNER: phase_n = PH_SKIP;
									CLS_PLUS:  phase_n = PH_DIGITS;
									CLS_MINUS: begin
										neg_n   = 1'b1;
										phase_n = PH_DIGITS;
									end
									CLS_DIGIT: begin
										acc_n   = {12'd0, q_op.digit};
										phase_n = PH_DIGITS;
									end
									default:   phase_n = PH_DONE;
								endcase
							end
							PH_DIGITS: begin
								if (q_op.cls == CLS_DIGIT) begin
									acc_n = acc_x10 + {12'd0, q_op.digit};
								end else begin
									phase_n = PH_DONE;
								end
							end
							default: phase_n = ph;
						endcase
					end
				end
			end
			OP_END, OP_DROP: begin
				if (q_op.kind == OP_END) begin
					if (fin_idx >= 2'd1) begin
						held_x_n = fin_pf;
					end
					if (fin_idx >= TOKENS_MAX) begin
						held_y_n = fin_ps;
					end
				end
				phase_n = PH_BETWEEN;
				idx_n   = '0;
				neg_n   = 1'b0;
				acc_n   = '0;
				pf_n    = '0;
				ps_n    = '0;
				zero_n  = 1'b0;
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BETWEEN;
			idx_q    <= '0;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			pf_q     <= '0;
			ps_q     <= '0;
			zero_q   <= 1'b0;
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (pop) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			neg_q    <= neg_n;
			acc_q    <= acc_n;
			pf_q     <= pf_n;
			ps_q     <= ps_n;
			zero_q   <= zero_n;
			held_x_q <= held_x_n;
			held_y_q <= held_y_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			flow_x_q <= held_x_n;
			flow_y_q <= held_y_n;
			tokens_q <= (q_op.kind == OP_END) ? fin_idx : 2'd0;
			status_q <= (q_op.kind == OP_END) ? LINE_PARSED : LINE_DROPPED;
		end
	end

	assign out_valid   = out_valid_q;
	assign flow_x      = flow_x_q;
	assign flow_y      = flow_y_q;
	assign tokens_used = tokens_q;
	assign line_status = status_q;

endmodule

/* hdl/two_integer_line_parser_unit.sv */
// Byte-stream line parser: takes one received character per beat and, at each CR or LF that
// closes a non-empty line, reports the held X and Y values after the first two space-separated
// tokens of that line have been read as signed decimal integers (16-bit wrap), with the count of
// values updated. A line that reaches LINE_BUFFER_SIZE-1 characters is dropped and reported with
// line_status set. Sustained rate is one byte per clock while no result is held: the front end
// keeps the line length and classifies each byte, a two-entry queue decouples it from the back
// end, and the back end runs the token parse (one multiply-by-ten-and-add per byte) and owns the
// result register. A byte that causes a result is written into the queue, popped by the back
// end and then captured in the result register, which raises out_valid; a held result stops
// the back end and, once the queue fills, the input.
module two_integer_line_parser_unit
	import tilp_pkg::*;
#(
	parameter int unsigned LINE_BUFFER_SIZE = 127
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] flow_x,
	output logic signed [15:0] flow_y,
	output logic [1:0]         tokens_used,
	output logic               line_status
);

	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	op_t  push_op;
	op_t  head_op;

	tilp_front #(
		.LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.in_ready (in_ready),
		.push     (push),
		.push_op  (push_op)
	);

	tilp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	tilp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_op        (head_op),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.flow_x      (flow_x),
		.flow_y      (flow_y),
		.tokens_used (tokens_used),
		.line_status (line_status)
	);

endmodule

/* tb/sv/two_integer_line_parser_unit_tb.sv */
`timescale 1ns / 100ps

module two_integer_line_parser_unit_tb;
	import tilp_pkg::*;

	localparam int LINE_LEN_MAX = 127;
	localparam int RANDOM_BYTES = 1425;

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_A  = 8'h61;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [1:0]         used;
		logic               status;
	} line_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] flow_x;
	logic signed [15:0] flow_y;
	logic [1:0]         tokens_used;
	logic               line_status;

	two_integer_line_parser_unit #(
		.LINE_BUFFER_SIZE(LINE_LEN_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.flow_x(flow_x),
		.flow_y(flow_y),
		.tokens_used(tokens_used),
		.line_status(line_status)
	);

	always #1 clk = ~clk;

	logic [7:0]   tx_bytes[$];
	line_result_t expected_lines[$];
	int           bytes_sent = 0;
	int           byte_total = 1;
	int           errors = 0;

	// line parser state mirror
	logic [6:0]  ln_count = '0;
	logic [1:0]  tok_idx = '0;
	phase_t      tok_phase = PH_BETWEEN;
	logic        neg = 1'b0;
	logic [15:0] acc = '0;
	logic [15:0] pend_x = '0;
	logic [15:0] pend_y = '0;
	logic        nul_seen = 1'b0;
	logic [15:0] held_x = '0;
	logic [15:0] held_y = '0;

	task automatic clear_line();
		ln_count = '0;
		tok_idx = '0;
		tok_phase = PH_BETWEEN;
		neg = 1'b0;
		acc = '0;
		pend_x = '0;
		pend_y = '0;
		nul_seen = 1'b0;
	endtask

	task automatic close_token();
		logic [15:0] v;
		if (tok_phase != PH_BETWEEN && tok_idx < TOKENS_MAX) begin
			v = neg ? (16'd0 - acc) : acc;
			if (tok_idx == 2'd0)
				pend_x = v;
			else
				pend_y = v;
			tok_idx++;
		end
		tok_phase = PH_BETWEEN;
	endtask

	task automatic parse_byte(input logic [7:0] c);
		line_result_t r;
		logic is_digit;
		is_digit = c >= CH_DIG0 && c <= CH_DIG9;
		if ((c == CH_LF || c == CH_CR) && ln_count != 0) begin
			close_token();
			if (tok_idx >= 2'd1)
				held_x = pend_x;
			if (tok_idx >= 2'd2)
				held_y = pend_y;
			r = '{held_x, held_y, tok_idx, LINE_PARSED};
			expected_lines.push_back(r);
			clear_line();
		end else begin
			ln_count++;
			if (!nul_seen) begin
				if (c == CH_NUL) begin
					nul_seen = 1'b1;
				end else if (c == CH_SPACE) begin
					close_token();
				end else begin
					if (tok_phase == PH_BETWEEN) begin
						if (tok_idx >= TOKENS_MAX) begin
							tok_phase = PH_DONE;
						end else begin
							tok_phase = PH_SKIP;
							neg = 1'b0;
							acc = '0;
						end
					end
					if (tok_phase == PH_SKIP) begin
						if (c >= CH_TAB && c <= CH_CR) begin
							// still leading whitespace
						end else if (c == CH_PLUS) begin
							tok_phase = PH_DIGITS;
						end else if (c == CH_MINUS) begin
							neg = 1'b1;
							tok_phase = PH_DIGITS;
						end else if (is_digit) begin
							acc = {12'd0, c[3:0]};
							tok_phase = PH_DIGITS;
						end else begin
							tok_phase = PH_DONE;
						end
					end else if (tok_phase == PH_DIGITS) begin
						if (is_digit)
							acc = acc * 16'd10 + {12'd0, c[3:0]};
						else
							tok_phase = PH_DONE;
					end
				end
			end
			if (ln_count >= LINE_LEN_MAX - 1) begin
				clear_line();
				r = '{held_x, held_y, 2'd0, LINE_DROPPED};
				expected_lines.push_back(r);
			end
		end
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			tx_bytes.push_back(s[i]);
	endtask

	task automatic push_number();
		int ndig;
		case ($urandom_range(7))
			0: tx_bytes.push_back($urandom_range(1) ? CH_TAB : CH_VT);
			1: tx_bytes.push_back(CH_FF);
			default: ;
		endcase
		case ($urandom_range(3))
			0: tx_bytes.push_back(CH_MINUS);
			1: tx_bytes.push_back(CH_PLUS);
			default: ;
		endcase
		ndig = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
		for (int i = 0; i < ndig; i++)
			tx_bytes.push_back(CH_DIG0 + 8'($urandom_range(9)));
		if ($urandom_range(9) == 0)
			tx_bytes.push_back(CH_A + 8'($urandom_range(25)));
	endtask

	task automatic push_line();
		int r;
		int ntok;
		int len;
		r = $urandom_range(99);
		if (r < 3) begin
			// long line, no terminators inside, gets dropped
			len = $urandom_range(LINE_LEN_MAX - 1, LINE_LEN_MAX + 30);
			for (int i = 0; i < len; i++)
				case ($urandom_range(2))
					0: tx_bytes.push_back(CH_SPACE);
					1: tx_bytes.push_back(CH_DIG0 + 8'($urandom_range(9)));
					default: tx_bytes.push_back(CH_A + 8'($urandom_range(25)));
				endcase
		end else if (r < 13) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				tx_bytes.push_back(8'($urandom_range(255)));
		end else begin
			if (r < 18)
				tx_bytes.push_back($urandom_range(1) ? CH_LF : CH_CR);
			if ($urandom_range(4) == 0)
				tx_bytes.push_back(CH_SPACE);
			ntok = ($urandom_range(2) != 0) ? 2 : $urandom_range(0, 4);
			for (int t = 0; t < ntok; t++) begin
				push_number();
				if ($urandom_range(19) == 0)
					tx_bytes.push_back(CH_NUL);
				if (t != ntok - 1 || $urandom_range(5) == 0)
					repeat ($urandom_range(1, 3)) tx_bytes.push_back(CH_SPACE);
			end
		end
		tx_bytes.push_back($urandom_range(1) ? CH_LF : CH_CR);
	endtask

	function automatic int phase_now();
		return (bytes_sent * 4) / byte_total;
	endfunction

	function automatic int tx_idle_pct();
		case (phase_now())
			1: return 56;
			3: return 36;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_stall_pct();
		case (phase_now())
			2: return 56;
			3: return 36;
			default: return 0;
		endcase
	endfunction

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_byte(rx_byte);
				bytes_sent <= bytes_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
					in_valid <= 1'b1;
					rx_byte <= tx_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= $urandom_range(99) >= rx_stall_pct();
	end

	task automatic report(input string what, input line_result_t want, input line_result_t got);
		errors++;
		if (errors <= 10)
			$display({"%s: expected x=%0d y=%0d used=%0d status=%0d,",
				" got x=%0d y=%0d used=%0d status=%0d"},
				what, $signed(want.x), $signed(want.y), want.used, want.status,
				$signed(got.x), $signed(got.y), got.used, got.status);
	endtask

	// result monitor
	always @(posedge clk) begin
		line_result_t got;
		line_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{flow_x, flow_y, tokens_used, line_status};
			if (expected_lines.size() == 0) begin
				report("result with none pending", '0, got);
			end else begin
				want = expected_lines.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.used !== want.used
						|| got.status !== want.status)
					report("line result mismatch", want, got);
			end
		end
	end

	initial begin
		// empty-line LF, sign and overflow, no-digit and extra tokens, zero byte, junk token
		tx_bytes.push_back(CH_LF);
		push_str("-5 +999999");
		tx_bytes.push_back(CH_LF);
		push_str("a  7 3");
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(8'h38);
		tx_bytes.push_back(CH_NUL);
		tx_bytes.push_back(8'h39);
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(CH_CR);
		while (tx_bytes.size() < RANDOM_BYTES + 25)
			push_line();
		byte_total = tx_bytes.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (tx_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_lines.size() != 0)
			errors++;
		if (errors == 0)
			$display("two_integer_line_parser_unit_tb: done, clean");
		else
			$display("two_integer_line_parser_unit_tb: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("two_integer_line_parser_unit_tb: done, errors");
		$finish;
	end

endmodule
